/* rtl/core/brfms_pkg.sv */
// ----------------------------------------------------------------------------
// Banked register file package
// Shared types, constants and helper functions for the banked register file
// with mode switch.
// ----------------------------------------------------------------------------
package brfms_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned REG_DEPTH  = 32;
  localparam int unsigned SPSR_DEPTH = 5;
  localparam int unsigned REG_AW     = $clog2(REG_DEPTH);
  localparam int unsigned SPSR_AW    = $clog2(SPSR_DEPTH);

  typedef logic [2:0] bank_t;

  localparam bank_t BANK_USR = 3'd0;
  localparam bank_t BANK_FIQ = 3'd1;
  localparam bank_t BANK_IRQ = 3'd2;
  localparam bank_t BANK_SVC = 3'd3;
  localparam bank_t BANK_ABT = 3'd4;
  localparam bank_t BANK_UND = 3'd5;

  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;
  localparam logic [4:0] MODE_SYS = 5'h1F;

  localparam logic [DATA_W-1:0] STATUS_RESET = 32'h0000_00D3;

  localparam logic [3:0] REG_LINK = 4'd14;
  localparam logic [3:0] REG_PC   = 4'd15;

  // Physical layout of the register RAM.
  localparam logic [REG_AW-1:0] FIQ_BASE  = 5'd16;
  localparam logic [REG_AW-1:0] PAIR_BASE = 5'd23;

  typedef enum logic [2:0] {
    REQ_READ_REG     = 3'd0,
    REQ_WRITE_REG    = 3'd1,
    REQ_WRITE_STATUS = 3'd2,
    REQ_EXCEPT       = 3'd3,
    REQ_READ_SAVED   = 3'd4,
    REQ_WRITE_SAVED  = 3'd5
  } req_t;

  typedef struct packed {
    logic  known;
    bank_t code;
  } mode_info_t;

  function automatic mode_info_t bank_of_mode(input logic [4:0] mode);
    mode_info_t info;
    info.known = 1'b1;
    info.code  = BANK_USR;
    unique case (mode)
      MODE_USR, MODE_SYS: info.code = BANK_USR;
      MODE_FIQ: info.code = BANK_FIQ;
      MODE_IRQ: info.code = BANK_IRQ;
      MODE_SVC: info.code = BANK_SVC;
      MODE_ABT: info.code = BANK_ABT;
      MODE_UND: info.code = BANK_UND;
      default:  info.known = 1'b0;
    endcase
    return info;
  endfunction

  function automatic logic [4:0] entry_mode(input logic [2:0] sel);
    logic [4:0] m;
    unique case (sel)
      3'd0:    m = MODE_SVC;
      3'd1:    m = MODE_UND;
      3'd2:    m = MODE_SVC;
      3'd3:    m = MODE_ABT;
      3'd4:    m = MODE_ABT;
      3'd5:    m = MODE_SVC;
      3'd6:    m = MODE_IRQ;
      default: m = MODE_FIQ;
    endcase
    return m;
  endfunction

  function automatic logic [REG_AW-1:0] phys_addr(input bank_t bank, input logic [3:0] idx);
    logic [REG_AW-1:0] a;
    logic [REG_AW-1:0] bank_off;
    a        = {1'b0, idx};
    bank_off = {1'b0, bank - BANK_IRQ, 1'b0};
    if (idx >= 4'd8 && idx <= REG_LINK) begin
      if (bank == BANK_FIQ) begin
        a = FIQ_BASE + {2'b00, idx[2:0]};
      end else if (idx >= 4'd13 && bank >= BANK_IRQ && bank <= BANK_UND) begin
        a = PAIR_BASE + bank_off + {4'b0000, idx[0] ^ 1'b1};
      end
    end
    return a;
  endfunction

  function automatic logic [SPSR_AW-1:0] spsr_index(input bank_t bank);
    return (bank == BANK_USR) ? '0 : SPSR_AW'(bank - BANK_FIQ);
  endfunction

  function automatic logic [DATA_W-1:0] pc_align(input logic [DATA_W-1:0] v,
                                                 input logic thumb);
    return thumb ? ({v[DATA_W-1:1], 1'b0} + 32'd2) : ({v[DATA_W-1:2], 2'b00} + 32'd4);
  endfunction

endpackage

/* rtl/core/brfms_ram.sv */
// ----------------------------------------------------------------------------
// Register file RAM
// Single write port, single read port RAM with a registered read.
// Per-entry valid bits make entries that were never written read as zero.
// ----------------------------------------------------------------------------
module brfms_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= valid[raddr] ? mem[raddr] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

endmodule

/* rtl/core/banked_register_file_mode_switch_unit.sv */
// ----------------------------------------------------------------------------
// Banked register file with mode switch
// The result strobe is registered from the execute state, or from the PC
// state for exception entry. A new item is taken only while not busy, after
// the read-then-write pass through the register RAM (entry writes link
// and PC through the one write port in the execute and PC states).
// Reset: status word 0xD3 in supervisor mode, all registers and saved status
// read as zero through valid bits, vector base zero. Results cannot be stalled.
// ----------------------------------------------------------------------------
module banked_register_file_mode_switch_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type,
  input  logic [3:0]  reg_index,
  input  logic [31:0] value,
  input  logic        save_old,
  input  logic [4:0]  vector,
  output logic        done,
  output logic [31:0] read_data,
  output logic [31:0] status_word,
  output logic        mode_unknown,
  output logic        no_saved_status,
  output logic        interrupt_recheck,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_PC   = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [31:0]          status_reg;
  logic [31:0]          status_next;
  brfms_pkg::bank_t     active_bank;
  brfms_pkg::bank_t     bank_next;
  logic [31:0]          vector_base;

  brfms_pkg::req_t      req_q;
  logic [3:0]           idx_q;
  logic [31:0]          val_q;
  logic                 save_q;
  logic [4:0]           vec_q;

  logic                          reg_we;
  logic [brfms_pkg::REG_AW-1:0]  reg_waddr;
  logic [31:0]                   reg_wdata;
  logic [brfms_pkg::REG_AW-1:0]  reg_raddr;
  logic [31:0]                   reg_rdata;
  logic                          sp_we;
  logic [brfms_pkg::SPSR_AW-1:0] sp_waddr;
  logic [31:0]                   sp_wdata;
  logic [brfms_pkg::SPSR_AW-1:0] sp_raddr;
  logic [31:0]                   sp_rdata;

  logic [31:0] res_rd;
  logic        res_unk;
  logic        res_nosp;
  logic        res_recheck;

  brfms_pkg::mode_info_t wr_map;
  brfms_pkg::mode_info_t cur_map;
  brfms_pkg::mode_info_t exc_map;
  logic [4:0]            exc_mode;
  brfms_pkg::bank_t      exc_bank;
  logic [31:0]           exc_status;
  logic                  accept;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign reg_raddr = (brfms_pkg::req_t'(req_type) == brfms_pkg::REQ_EXCEPT)
                   ? brfms_pkg::phys_addr(active_bank, brfms_pkg::REG_PC)
                   : brfms_pkg::phys_addr(active_bank, reg_index);
  assign sp_raddr  = brfms_pkg::spsr_index(active_bank);

  assign wr_map     = brfms_pkg::bank_of_mode(val_q[4:0]);
  assign exc_mode   = brfms_pkg::entry_mode(vec_q[4:2]);
  assign exc_map    = brfms_pkg::bank_of_mode(exc_mode);
  assign exc_bank   = exc_map.code;
  assign exc_status = {status_reg[31:8], 1'b1, status_reg[6], 1'b0, exc_mode};
  assign cur_map    = brfms_pkg::bank_of_mode(status_reg[4:0]);

  always_comb begin
    state_next  = state;
    status_next = status_reg;
    bank_next   = active_bank;
    reg_we      = 1'b0;
    reg_waddr   = brfms_pkg::phys_addr(active_bank, idx_q);
    reg_wdata   = val_q;
    sp_we       = 1'b0;
    sp_waddr    = brfms_pkg::spsr_index(active_bank);
    sp_wdata    = val_q;
    res_rd      = '0;
    res_unk     = 1'b0;
    res_nosp    = 1'b0;
    res_recheck = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        case (req_q)
          brfms_pkg::REQ_READ_REG: begin
            res_rd = reg_rdata;
          end
          brfms_pkg::REQ_WRITE_REG: begin
            reg_we = 1'b1;
            if (idx_q == brfms_pkg::REG_PC) begin
              reg_wdata = brfms_pkg::pc_align(val_q, status_reg[5]);
            end
          end
          brfms_pkg::REQ_WRITE_STATUS: begin
            if (wr_map.known) begin
              bank_next = wr_map.code;
            end
            sp_waddr    = brfms_pkg::spsr_index(bank_next);
            sp_wdata    = status_reg;
            sp_we       = save_q && (bank_next != brfms_pkg::BANK_USR);
            status_next = val_q;
            res_unk     = !wr_map.known;
            res_recheck = 1'b1;
          end
          brfms_pkg::REQ_EXCEPT: begin
            state_next  = ST_PC;
            bank_next   = exc_bank;
            status_next = exc_status;
            sp_we       = 1'b1;
            sp_waddr    = brfms_pkg::spsr_index(exc_bank);
            sp_wdata    = status_reg;
            reg_we      = 1'b1;
            reg_waddr   = brfms_pkg::phys_addr(exc_bank, brfms_pkg::REG_LINK);
            reg_wdata   = reg_rdata + {29'd0, status_reg[5], 1'b0};
            res_recheck = 1'b1;
          end
          brfms_pkg::REQ_READ_SAVED: begin
            if (active_bank == brfms_pkg::BANK_USR) begin
              res_nosp = 1'b1;
            end else begin
              res_rd = sp_rdata;
            end
          end
          brfms_pkg::REQ_WRITE_SAVED: begin
            if (active_bank == brfms_pkg::BANK_USR) begin
              res_nosp = 1'b1;
            end else begin
              sp_we = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      ST_PC: begin
        state_next = ST_IDLE;
        reg_we     = 1'b1;
        reg_waddr  = brfms_pkg::phys_addr(active_bank, brfms_pkg::REG_PC);
        reg_wdata  = brfms_pkg::pc_align(vector_base + {27'd0, vec_q}, 1'b0);
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      status_reg  <= brfms_pkg::STATUS_RESET;
      active_bank <= brfms_pkg::BANK_SVC;
      vector_base <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      status_reg  <= status_next;
      active_bank <= bank_next;
      done        <= ((state == ST_EXEC) && (req_q != brfms_pkg::REQ_EXCEPT))
                     || (state == ST_PC);
      if (cfg_valid && cfg_ready) begin
        vector_base <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= brfms_pkg::req_t'(req_type);
      idx_q  <= reg_index;
      val_q  <= value;
      save_q <= save_old;
      vec_q  <= vector;
    end
    if (state == ST_EXEC) begin
      read_data         <= res_rd;
      status_word       <= status_next;
      mode_unknown      <= res_unk;
      no_saved_status   <= res_nosp;
      interrupt_recheck <= res_recheck;
    end
  end

  brfms_ram #(
    .DEPTH(brfms_pkg::REG_DEPTH),
    .WIDTH(brfms_pkg::DATA_W)
  ) u_reg_ram (
    .clk  (clk),
    .rst  (rst),
    .we   (reg_we),
    .waddr(reg_waddr),
    .wdata(reg_wdata),
    .raddr(reg_raddr),
    .rdata(reg_rdata)
  );

  brfms_ram #(
    .DEPTH(brfms_pkg::SPSR_DEPTH),
    .WIDTH(brfms_pkg::DATA_W)
  ) u_spsr_ram (
    .clk  (clk),
    .rst  (rst),
    .we   (sp_we),
    .waddr(sp_waddr),
    .wdata(sp_wdata),
    .raddr(sp_raddr),
    .rdata(sp_rdata)
  );

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_EXEC || $past(state) == ST_PC))
    else $error("Result strobe without an item in flight.");

  a_bank_matches_mode: assert property (@(posedge clk) disable iff (rst)
    cur_map.known |-> (active_bank == cur_map.code))
    else $error("Active bank disagrees with a known mode in the status word.");

  a_entry_masks_irq: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PC) |-> (status_reg[7] && !status_reg[5]))
    else $error("Exception entry left IRQ unmasked or Thumb set.");

endmodule

/* test/rf_check_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banked register file scoreboard
// Keeps its own copy of the register banks, saved status words, status word
// and vector base. It predicts the one result of every accepted item and
// checks each result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
package rf_check_pkg;
  import brfms_pkg::*;

  localparam logic [2:0]  REQ_SPARE_6    = 3'd6;
  localparam logic [2:0]  REQ_SPARE_7    = 3'd7;
  localparam logic [31:0] PSR_THUMB      = 32'h0000_0020;
  localparam logic [31:0] PSR_IRQ_MASK   = 32'h0000_0080;
  localparam logic [31:0] PSR_MODE_FIELD = 32'h0000_003F;

  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] status_word;
    logic        mode_unknown;
    logic        no_saved_status;
    logic        interrupt_recheck;
  } rf_result_t;

  class rf_scoreboard;
    logic [31:0] phys_regs[31];
    logic [31:0] saved_psr[5];
    logic [31:0] cpsr;
    bank_t       bank;
    logic [31:0] vec_base;
    logic [4:0]  entry_mode_tbl[8];
    rf_result_t  expected_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned req_seen[8];
    int unsigned unknown_modes;
    int unsigned absent_saved;

    function new();
      entry_mode_tbl = '{MODE_SVC, MODE_UND, MODE_SVC, MODE_ABT,
                         MODE_ABT, MODE_SVC, MODE_IRQ, MODE_FIQ};
      foreach (phys_regs[i]) phys_regs[i] = '0;
      foreach (saved_psr[i]) saved_psr[i] = '0;
      foreach (req_seen[i]) req_seen[i] = 0;
      cpsr          = STATUS_RESET;
      bank          = BANK_SVC;
      vec_base      = '0;
      errors        = 0;
      checked       = 0;
      unknown_modes = 0;
      absent_saved  = 0;
    endfunction

    function void set_vector_base(input logic [31:0] v);
      vec_base = v;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Registers 0..15 are the user copies, 16..22 the FIQ copies of r8..r14,
    // and 23..30 the r13/r14 pairs of IRQ, supervisor, abort and undefined.
    function int unsigned locate(input logic [3:0] idx);
      if (idx >= 4'd8 && idx <= REG_LINK) begin
        if (bank == BANK_FIQ) return 16 + int'(idx) - 8;
        if (idx >= 4'd13 && bank >= BANK_IRQ && bank <= BANK_UND)
          return 23 + 2 * (int'(bank) - int'(BANK_IRQ)) + int'(idx) - 13;
      end
      return int'(idx);
    endfunction

    function bit lookup_bank(input logic [4:0] mode, output bank_t b);
      b = BANK_USR;
      case (mode)
        MODE_USR, MODE_SYS: b = BANK_USR;
        MODE_FIQ: b = BANK_FIQ;
        MODE_IRQ: b = BANK_IRQ;
        MODE_SVC: b = BANK_SVC;
        MODE_ABT: b = BANK_ABT;
        MODE_UND: b = BANK_UND;
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function bit write_status(input logic [31:0] v, input bit save);
      bank_t b;
      bit    known;
      known = lookup_bank(v[4:0], b);
      if (known) bank = b;
      if (save && bank != BANK_USR) saved_psr[int'(bank) - 1] = cpsr;
      cpsr = v;
      return !known;
    endfunction

    function void set_pc(input logic [31:0] v);
      if ((cpsr & PSR_THUMB) != 0) phys_regs[REG_PC] = {v[31:1], 1'b0} + 32'd2;
      else phys_regs[REG_PC] = {v[31:2], 2'b00} + 32'd4;
    endfunction

    function void note_request(input logic [2:0] req, input logic [3:0] idx,
                               input logic [31:0] val, input logic save,
                               input logic [4:0] vec);
      rf_result_t  r;
      logic [31:0] ns;
      logic [31:0] link;
      r = '0;
      req_seen[req]++;
      case (req)
        REQ_READ_REG: r.read_data = phys_regs[locate(idx)];
        REQ_WRITE_REG: begin
          if (idx == REG_PC) set_pc(val);
          else phys_regs[locate(idx)] = val;
        end
        REQ_WRITE_STATUS: begin
          r.mode_unknown      = write_status(val, save);
          r.interrupt_recheck = 1'b1;
        end
        REQ_EXCEPT: begin
          ns = (cpsr & ~PSR_MODE_FIELD) | PSR_IRQ_MASK | {27'd0, entry_mode_tbl[vec[4:2]]};
          void'(write_status(ns, 1'b1));
          link = phys_regs[REG_PC];
          if ((saved_psr[int'(bank) - 1] & PSR_THUMB) != 0) link = link + 32'd2;
          phys_regs[locate(REG_LINK)] = link;
          set_pc(vec_base + {27'd0, vec});
          r.interrupt_recheck = 1'b1;
        end
        REQ_READ_SAVED: begin
          if (bank == BANK_USR) r.no_saved_status = 1'b1;
          else r.read_data = saved_psr[int'(bank) - 1];
        end
        REQ_WRITE_SAVED: begin
          if (bank == BANK_USR) r.no_saved_status = 1'b1;
          else saved_psr[int'(bank) - 1] = val;
        end
        default: ;
      endcase
      r.status_word = cpsr;
      if (r.mode_unknown) unknown_modes++;
      if (r.no_saved_status) absent_saved++;
      expected_q.push_back(r);
    endfunction

    function void check_result(input rf_result_t got);
      rf_result_t exp;
      if (expected_q.size() == 0) begin
        $error("Result strobe with no item outstanding.");
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (got.read_data !== exp.read_data) begin
        $error("read_data: expected %h, got %h", exp.read_data, got.read_data);
        errors++;
      end
      if (got.status_word !== exp.status_word) begin
        $error("status_word: expected %h, got %h", exp.status_word, got.status_word);
        errors++;
      end
      if (got.mode_unknown !== exp.mode_unknown) begin
        $error("mode_unknown: expected %b, got %b", exp.mode_unknown, got.mode_unknown);
        errors++;
      end
      if (got.no_saved_status !== exp.no_saved_status) begin
        $error("no_saved_status: expected %b, got %b",
               exp.no_saved_status, got.no_saved_status);
        errors++;
      end
      if (got.interrupt_recheck !== exp.interrupt_recheck) begin
        $error("interrupt_recheck: expected %b, got %b",
               exp.interrupt_recheck, got.interrupt_recheck);
        errors++;
      end
    endfunction
  endclass

endpackage

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banked register file testbench
// Drives register, status, exception and saved-status items through the
// command port, changes the vector base between phases, and checks every
// result against the scoreboard's prediction under varying start gaps.
// ----------------------------------------------------------------------------
module testbench;
  import brfms_pkg::*;
  import rf_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 100000;
  localparam int unsigned RANDOM_PER_PHASE = 180;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  req_type;
  logic [3:0]  reg_index;
  logic [31:0] value;
  logic        save_old;
  logic [4:0]  vector;
  logic        done;
  logic [31:0] read_data;
  logic [31:0] status_word;
  logic        mode_unknown;
  logic        no_saved_status;
  logic        interrupt_recheck;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  rf_scoreboard sb = new();
  int unsigned  cycles = 0;
  int unsigned  idle_pct = 0;
  logic [4:0]   mode_list[7] = '{MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC,
                                 MODE_ABT, MODE_UND, MODE_SYS};

  banked_register_file_mode_switch_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        sb.check_result(rf_result_t'{read_data, status_word, mode_unknown,
                                     no_saved_status, interrupt_recheck});
      if (start && !busy) sb.note_request(req_type, reg_index, value, save_old, vector);
      if (cfg_valid && cfg_ready) sb.set_vector_base(cfg_data);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_request(input logic [2:0] rq, input logic [3:0] idx,
                              input logic [31:0] val, input logic save,
                              input logic [4:0] vec);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    req_type  <= rq;
    reg_index <= idx;
    value     <= val;
    save_old  <= save;
    vector    <= vec;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random();
    logic [2:0]  rq;
    logic [3:0]  idx;
    logic [31:0] val;
    int unsigned pick;
    pick = $urandom_range(99);
    val  = $urandom;
    idx  = $urandom_range(1) ? 4'($urandom_range(15, 8)) : 4'($urandom_range(15));
    if (pick < 28) rq = REQ_READ_REG;
    else if (pick < 50) rq = REQ_WRITE_REG;
    else if (pick < 66) rq = REQ_WRITE_STATUS;
    else if (pick < 77) rq = REQ_EXCEPT;
    else if (pick < 86) rq = REQ_READ_SAVED;
    else if (pick < 95) rq = REQ_WRITE_SAVED;
    else rq = $urandom_range(1) ? REQ_SPARE_6 : REQ_SPARE_7;
    if (rq == REQ_WRITE_STATUS && $urandom_range(3) != 0)
      val[4:0] = mode_list[$urandom_range(6)];
    send_request(rq, idx, val, 1'($urandom_range(1)), 5'($urandom_range(31)));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_vector_base(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] bases[6];
    int unsigned regimes[3];
    rst       <= 1'b1;
    start     <= 1'b0;
    req_type  <= REQ_READ_REG;
    reg_index <= '0;
    value     <= '0;
    save_old  <= 1'b0;
    vector    <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    bases   = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, 32'hFFFF_FFFC, $urandom,
                32'h8000_0000};
    regimes = '{19, 66, 0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_vector_base(32'hFFFF_FFF0);
    send_request(REQ_READ_REG, REG_PC, 32'h0, 1'b0, 5'd0);
    send_request(REQ_WRITE_REG, 4'd0, 32'hFFFF_FFFF, 1'b0, 5'd0);
    send_request(REQ_WRITE_REG, REG_PC, 32'hFFFF_FFFF, 1'b0, 5'd0);
    send_request(REQ_READ_REG, REG_PC, 32'h0, 1'b0, 5'd0);
    send_request(REQ_WRITE_REG, 4'd13, 32'h1234_5678, 1'b0, 5'd0);
    send_request(REQ_READ_SAVED, 4'd0, 32'h0, 1'b0, 5'd0);
    send_request(REQ_WRITE_SAVED, 4'd0, 32'hFFFF_FFFF, 1'b0, 5'd0);
    send_request(REQ_WRITE_STATUS, 4'd0, 32'h0000_0000, 1'b1, 5'd0);
    send_request(REQ_WRITE_STATUS, 4'd0, 32'hFFFF_FFF0, 1'b1, 5'd0);
    send_request(REQ_READ_SAVED, 4'd0, 32'h0, 1'b0, 5'd0);
    send_request(REQ_WRITE_SAVED, 4'd0, 32'hDEAD_BEEF, 1'b0, 5'd0);
    send_request(REQ_WRITE_REG, REG_PC, 32'hFFFF_FFFF, 1'b0, 5'd0);
    send_request(REQ_READ_REG, REG_LINK, 32'h0, 1'b0, 5'd0);
    for (int i = 0; i < 8; i++)
      send_request(REQ_EXCEPT, 4'($urandom_range(15)), $urandom, 1'b0, 5'(4 * i + (i % 4)));
    send_request(REQ_SPARE_6, REG_PC, 32'hFFFF_FFFF, 1'b1, 5'd31);
    send_request(REQ_SPARE_7, REG_PC, 32'hFFFF_FFFF, 1'b1, 5'd31);
    send_request(REQ_WRITE_STATUS, 4'd0, 32'h0000_001F, 1'b1, 5'd0);
    send_request(REQ_READ_REG, 4'd8, 32'h0, 1'b0, 5'd0);

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      write_vector_base(bases[phase]);
      idle_pct = regimes[phase / 2];
      repeat (RANDOM_PER_PHASE) send_random();
    end
    drain();
    repeat (8) @(posedge clk);

    $display("Checked %0d results: %0d reads, %0d writes, %0d status writes, %0d entries,",
             sb.checked, sb.req_seen[REQ_READ_REG], sb.req_seen[REQ_WRITE_REG],
             sb.req_seen[REQ_WRITE_STATUS], sb.req_seen[REQ_EXCEPT]);
    $display("%0d saved-status accesses, %0d unknown modes, %0d accesses with no saved status.",
             sb.req_seen[REQ_READ_SAVED] + sb.req_seen[REQ_WRITE_SAVED],
             sb.unknown_modes, sb.absent_saved);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/brfms_pkg.sv
rtl/core/brfms_ram.sv
rtl/core/banked_register_file_mode_switch_unit.sv
test/rf_check_pkg.sv
test/testbench.sv
